@@ hw/rtl/srsr_pkg.sv @@
`default_nettype none
package srsr_pkg;

    localparam int SLOTS_DEF      = 16;
    localparam int PAGE_SHIFT_DEF = 12;
    localparam int MAX_RESULTS    = 16;

    localparam int ADDR_W  = 48;
    localparam int RPAGE_W = 17;
    localparam int ID_W    = 32;
    localparam int PT_W    = 52;
    localparam int CAP_W   = 16;
    localparam int CPAGE_W = 16;
    localparam int TALLY_W = 7;
    localparam int IN_W    = 200;
    localparam int OUT_W   = 144;

    localparam logic REG_WINDOW_BASE  = 1'b0;
    localparam logic REG_REGION_PAGES = 1'b1;

    typedef enum logic [2:0] {
        MODE_MAP      = 3'd0,
        MODE_ROLLBACK = 3'd1,
        MODE_UNMAP    = 3'd2,
        MODE_INVAL    = 3'd3,
        MODE_DRAIN    = 3'd4,
        MODE_RESET    = 3'd5,
        MODE_COUNT    = 3'd6,
        MODE_IS_OWNER = 3'd7
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_REJECTED  = 2'd1,
        ST_FULL      = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_t;

    typedef struct packed {
        mode_t                mode;
        logic                 reject;
        logic [ID_W-1:0]      task_id;
        logic [ID_W-1:0]      task_gen;
        logic [PT_W-1:0]      page_table;
        logic [CAP_W-1:0]     cap_handle;
        logic [CPAGE_W-1:0]   cap_pages;
        logic [ADDR_W-1:0]    region_va;
    } cmd_t;

    typedef struct packed {
        logic [TALLY_W-1:0]   tally;
        logic                 release_valid;
        logic [CAP_W-1:0]     release_cap;
        logic [PT_W-1:0]      freed_table;
        logic [RPAGE_W-1:0]   freed_pages;
        logic [ADDR_W-1:0]    mapped_va;
        status_t              status;
    } res_t;

endpackage
`default_nettype wire

@@ hw/rtl/srsr_front.sv @@
`default_nettype none
module srsr_front
    import srsr_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic [IN_W-1:0]    s_tdata,
    input  wire logic [2:0]         s_tuser,
    input  wire logic [RPAGE_W-1:0] region_pages,
    output logic                    push_valid,
    input  wire logic               push_ready,
    output cmd_t                    push_cmd
);

    cmd_t cmd_reg;
    logic valid_reg;
    cmd_t cmd_next;
    logic revoked;
    logic is_user;
    logic phys_zero;

    // Incoming transfer is classified and registered before it enters the queue.
    assign s_tready = !valid_reg || push_ready;
    assign push_valid = valid_reg;
    assign push_cmd = cmd_reg;

    always_comb
    begin
        cmd_next.mode       = mode_t'(s_tuser);
        cmd_next.task_id    = s_tdata[31:0];
        cmd_next.task_gen   = s_tdata[63:32];
        cmd_next.page_table = s_tdata[115:64];
        cmd_next.cap_handle = s_tdata[131:116];
        cmd_next.cap_pages  = s_tdata[150:135];
        cmd_next.region_va  = s_tdata[198:151];
        revoked   = s_tdata[132];
        is_user   = s_tdata[133];
        phys_zero = s_tdata[134];
        cmd_next.reject = revoked || !is_user || phys_zero
                          || (cmd_next.cap_pages == '0)
                          || ({1'b0, cmd_next.cap_pages} > region_pages)
                          || (cmd_next.page_table == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            cmd_reg <= cmd_next;
        end
    end

endmodule
`default_nettype wire

@@ hw/rtl/srsr_queue.sv @@
`default_nettype none
module srsr_queue
    import srsr_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push_valid,
    output logic      push_ready,
    input  cmd_t      push_cmd,
    output logic      pop_valid,
    input  wire logic pop_ready,
    output cmd_t      pop_cmd
);

    cmd_t       mem [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       do_push;
    logic       do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_cmd    = mem[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule
`default_nettype wire

@@ hw/rtl/srsr_back.sv @@
`default_nettype none
module srsr_back
    import srsr_pkg::*;
#(
    parameter int SLOTS      = SLOTS_DEF,
    parameter int PAGE_SHIFT = PAGE_SHIFT_DEF
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               pop_valid,
    output logic                    pop_ready,
    input  cmd_t                    pop_cmd,
    input  wire logic [ADDR_W-1:0]  window_base,
    input  wire logic [RPAGE_W-1:0] region_pages,
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output res_t                    m_res,
    output logic                    m_last
);

    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_EVAL = 5'b00010,
        S_PREP = 5'b00100,
        S_CALC = 5'b01000,
        S_EMIT = 5'b10000
    } state_t;

    state_t state_reg;
    cmd_t   cmd_reg;

    logic [SLOTS-1:0]   used_reg;
    logic [ID_W-1:0]    owner_mem [SLOTS];
    logic [ID_W-1:0]    gen_mem   [SLOTS];
    logic [CAP_W-1:0]   cap_mem   [SLOTS];
    logic [PT_W-1:0]    root_mem  [SLOTS];
    logic [ADDR_W-1:0]  addr_mem  [SLOTS];
    logic [CPAGE_W-1:0] pages_mem [SLOTS];

    logic [SLOTS-1:0]   match_next;
    logic [SLOTS-1:0]   match_reg;
    logic [SW-1:0]      idx_reg;
    logic               hit_reg;
    logic [TALLY_W-1:0] cnt_reg;
    logic [TALLY_W-1:0] rem_reg;
    logic [TALLY_W-1:0] live_reg;
    logic [TALLY_W-1:0] tally_reg;
    logic [ADDR_W-1:0]  map_addr_reg;

    logic [SW-1:0]      low_idx;
    logic [TALLY_W-1:0] pop_cnt;
    logic [ADDR_W-1:0]  stride;
    logic [ADDR_W-1:0]  product;
    logic [TALLY_W-1:0] cnt_clamped;

    logic    out_load;
    logic    loop_mode;
    res_t    res_next;
    logic    last_next;
    logic    free_en;
    logic [SW-1:0] free_idx;
    logic    set_en;
    logic    done;
    logic    m_tvalid_reg;

    assign pop_ready = (state_reg == S_IDLE);
    assign loop_mode = (cmd_reg.mode == MODE_INVAL) || (cmd_reg.mode == MODE_DRAIN)
                       || (cmd_reg.mode == MODE_RESET);
    assign stride  = ADDR_W'({region_pages, {PAGE_SHIFT{1'b0}}});
    assign product = ADDR_W'(idx_reg * stride);
    assign cnt_clamped = (cnt_reg > TALLY_W'(MAX_RESULTS)) ? TALLY_W'(MAX_RESULTS) : cnt_reg;

    // Parallel compare of the request against every slot.
    always_comb
    begin
        for (int i = 0; i < SLOTS; i++)
        begin
            logic addr_hit;
            logic task_hit;
            addr_hit = used_reg[i] && (addr_mem[i] == cmd_reg.region_va);
            task_hit = (owner_mem[i] == cmd_reg.task_id) && (gen_mem[i] == cmd_reg.task_gen);
            unique case (cmd_reg.mode)
                MODE_MAP:      match_next[i] = !used_reg[i];
                MODE_ROLLBACK: match_next[i] = addr_hit && (cap_mem[i] == cmd_reg.cap_handle);
                MODE_UNMAP:    match_next[i] = addr_hit && task_hit;
                MODE_IS_OWNER: match_next[i] = addr_hit && task_hit;
                MODE_INVAL:    match_next[i] = used_reg[i] && (cap_mem[i] == cmd_reg.cap_handle);
                MODE_DRAIN:    match_next[i] = used_reg[i] && (owner_mem[i] == cmd_reg.task_id);
                MODE_RESET:    match_next[i] = used_reg[i];
                MODE_COUNT:    match_next[i] = 1'b0;
                default:       match_next[i] = 1'b0;
            endcase
        end
    end

    always_comb
    begin
        low_idx = '0;
        pop_cnt = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (match_reg[i])
            begin
                low_idx = SW'(i);
            end
        end
        for (int i = 0; i < SLOTS; i++)
        begin
            pop_cnt = pop_cnt + TALLY_W'(match_reg[i]);
        end
    end

    always_comb
    begin
        out_load  = (state_reg == S_EMIT) && (!m_tvalid_reg || m_tready);
        res_next  = '0;
        res_next.tally = tally_reg;
        last_next = 1'b1;
        free_en   = 1'b0;
        free_idx  = idx_reg;
        set_en    = 1'b0;
        unique case (cmd_reg.mode)
            MODE_MAP:
            begin
                if (cmd_reg.reject)
                begin
                    res_next.status = ST_REJECTED;
                end
                else if (!hit_reg)
                begin
                    res_next.status = ST_FULL;
                end
                else
                begin
                    res_next.status = ST_OK;
                    res_next.mapped_va = map_addr_reg;
                    set_en = 1'b1;
                end
            end
            MODE_ROLLBACK, MODE_UNMAP:
            begin
                if (cmd_reg.mode == MODE_ROLLBACK)
                begin
                    res_next.status = ST_REJECTED;
                end
                else
                begin
                    res_next.status = hit_reg ? ST_OK : ST_NOT_FOUND;
                end
                free_en = hit_reg;
            end
            MODE_INVAL, MODE_DRAIN, MODE_RESET:
            begin
                res_next.status = ST_OK;
                if (rem_reg != '0)
                begin
                    free_en   = 1'b1;
                    free_idx  = low_idx;
                    last_next = (rem_reg == TALLY_W'(1));
                end
            end
            default:
            begin
                res_next.status = ST_OK;
            end
        endcase
        if (free_en)
        begin
            res_next.mapped_va     = addr_mem[free_idx];
            res_next.freed_pages   = RPAGE_W'(pages_mem[free_idx]);
            res_next.freed_table   = root_mem[free_idx];
            res_next.release_cap   = cap_mem[free_idx];
            res_next.release_valid = 1'b1;
        end
        done = out_load && last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            used_reg     <= '0;
            live_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
            if (out_load)
            begin
                m_tvalid_reg <= 1'b1;
            end
            if (out_load && free_en)
            begin
                used_reg[free_idx] <= 1'b0;
            end
            if (out_load && set_en)
            begin
                used_reg[idx_reg] <= 1'b1;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (pop_valid)
                    begin
                        state_reg <= S_EVAL;
                    end
                end
                S_EVAL: state_reg <= S_PREP;
                S_PREP: state_reg <= S_CALC;
                S_CALC: state_reg <= S_EMIT;
                S_EMIT:
                begin
                    if (done)
                    begin
                        state_reg <= S_IDLE;
                        if (cmd_reg.mode != MODE_IS_OWNER)
                        begin
                            live_reg <= tally_reg;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && pop_valid)
        begin
            cmd_reg <= pop_cmd;
        end
        if (state_reg == S_EVAL)
        begin
            match_reg <= match_next;
        end
        if (state_reg == S_PREP)
        begin
            idx_reg <= low_idx;
            hit_reg <= (match_reg != '0);
            cnt_reg <= pop_cnt;
        end
        if (state_reg == S_CALC)
        begin
            map_addr_reg <= window_base + product;
            rem_reg      <= cnt_clamped;
            unique case (cmd_reg.mode)
                MODE_MAP:
                    tally_reg <= live_reg + TALLY_W'(!cmd_reg.reject && hit_reg);
                MODE_ROLLBACK, MODE_UNMAP:
                    tally_reg <= live_reg - TALLY_W'(hit_reg);
                MODE_INVAL, MODE_DRAIN, MODE_RESET:
                    tally_reg <= live_reg - cnt_clamped;
                MODE_IS_OWNER:
                    tally_reg <= TALLY_W'(hit_reg);
                default:
                    tally_reg <= live_reg;
            endcase
        end
        if (out_load && loop_mode && free_en)
        begin
            match_reg[free_idx] <= 1'b0;
            rem_reg <= rem_reg - TALLY_W'(1);
        end
        if (out_load)
        begin
            m_res  <= res_next;
            m_last <= last_next;
        end
        if (out_load && set_en)
        begin
            owner_mem[idx_reg] <= cmd_reg.task_id;
            gen_mem[idx_reg]   <= cmd_reg.task_gen;
            cap_mem[idx_reg]   <= cmd_reg.cap_handle;
            root_mem[idx_reg]  <= cmd_reg.page_table;
            addr_mem[idx_reg]  <= map_addr_reg;
            pages_mem[idx_reg] <= cmd_reg.cap_pages;
        end
    end

    assign m_tvalid = m_tvalid_reg;

endmodule
`default_nettype wire

@@ hw/rtl/shared_region_slot_registry_core.sv @@
// A command goes from the queue head to its first result in steps: it leaves the queue,
// then compare, priority/population count, address multiply and result load.
// Commands that free several slots give one further result per cycle while m_tready is high, up to sixteen.
// The back end takes the next command only once the last result of the current one is loaded.
// Reset (rst_n low, asynchronous) empties the slot table and queue and restores the
// configuration registers to base 0 and one page per region; no clearing pass is needed.
`default_nettype none
module shared_region_slot_registry_core
    import srsr_pkg::*;
#(
    parameter int SLOTS      = SLOTS_DEF,
    parameter int PAGE_SHIFT = PAGE_SHIFT_DEF
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    // task_id, task_gen, page_table, cap_handle, cap_revoked, cap_is_user,
    // cap_phys_zero, cap_pages, region_va, zero pad
    input  wire logic [IN_W-1:0]   s_tdata,
    // mode
    input  wire logic [2:0]        s_tuser,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    // status, mapped_va, freed_pages, freed_table, release_cap, release_valid, tally, zero pad
    output logic [OUT_W-1:0]       m_tdata,
    output logic                   m_tlast,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic              cfg_index,
    input  wire logic [ADDR_W-1:0] cfg_data
);

    logic [ADDR_W-1:0]  window_base_reg;
    logic [RPAGE_W-1:0] region_pages_reg;
    logic push_valid;
    logic push_ready;
    cmd_t push_cmd;
    logic pop_valid;
    logic pop_ready;
    cmd_t pop_cmd;
    res_t res;

    assign cfg_ready = 1'b1;
    assign m_tdata = {1'b0, res};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_base_reg  <= '0;
            region_pages_reg <= RPAGE_W'(1);
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_WINDOW_BASE:  window_base_reg  <= cfg_data;
                REG_REGION_PAGES: region_pages_reg <= cfg_data[RPAGE_W-1:0];
                default:          window_base_reg  <= window_base_reg;
            endcase
        end
    end

    srsr_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .region_pages (region_pages_reg),
        .push_valid   (push_valid),
        .push_ready   (push_ready),
        .push_cmd     (push_cmd)
    );

    srsr_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_cmd    (pop_cmd)
    );

    srsr_back #(
        .SLOTS      (SLOTS),
        .PAGE_SHIFT (PAGE_SHIFT)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .pop_valid    (pop_valid),
        .pop_ready    (pop_ready),
        .pop_cmd      (pop_cmd),
        .window_base  (window_base_reg),
        .region_pages (region_pages_reg),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_res        (res),
        .m_last       (m_tlast)
    );

endmodule
`default_nettype wire

@@ tb/tb.sv @@
`default_nettype none
module tb;
    import srsr_pkg::*;

    localparam int NSLOT = 16;
    localparam int WATCHDOG_CYCLES = 5000;
    localparam logic [63:0] MASK48 = 64'hFFFF_FFFF_FFFF;

    typedef struct {
        status_t              status;
        logic [ADDR_W-1:0]    mapped_va;
        logic [RPAGE_W-1:0]   freed_pages;
        logic [PT_W-1:0]      freed_table;
        logic [CAP_W-1:0]     release_cap;
        logic                 release_valid;
        logic [TALLY_W-1:0]   tally;
        logic                 last;
    } slot_result_t;

    class slot_registry_scoreboard;
        logic                 used [NSLOT];
        logic [ID_W-1:0]      owner [NSLOT];
        logic [ID_W-1:0]      gen [NSLOT];
        logic [CAP_W-1:0]     cap [NSLOT];
        logic [PT_W-1:0]      root [NSLOT];
        logic [ADDR_W-1:0]    addr [NSLOT];
        logic [RPAGE_W-1:0]   npages [NSLOT];
        logic [ADDR_W-1:0]    base;
        logic [RPAGE_W-1:0]   rpages;
        slot_result_t         pending [$];
        int                   errors;

        function new();
            base = '0;
            rpages = 1;
            errors = 0;
            for (int i = 0; i < NSLOT; i++)
            begin
                used[i] = 0; owner[i] = 0; gen[i] = 0; cap[i] = 0;
                root[i] = 0; addr[i] = 0; npages[i] = 0;
            end
        endfunction

        function void write_reg(logic idx, logic [ADDR_W-1:0] value);
            if (idx == REG_WINDOW_BASE)
                base = value;
            else
                rpages = value[RPAGE_W-1:0];
        endfunction

        function slot_result_t plain(status_t st);
            slot_result_t r;
            r.status = st; r.mapped_va = 0; r.freed_pages = 0; r.freed_table = 0;
            r.release_cap = 0; r.release_valid = 0; r.tally = 0; r.last = 0;
            return r;
        endfunction

        function slot_result_t release_slot(status_t st, int i);
            slot_result_t r;
            r = plain(st);
            r.mapped_va = addr[i]; r.freed_pages = npages[i]; r.freed_table = root[i];
            r.release_cap = cap[i]; r.release_valid = 1;
            used[i] = 0;
            return r;
        endfunction

        function void wipe(int i);
            used[i] = 0; owner[i] = 0; gen[i] = 0; cap[i] = 0;
            root[i] = 0; addr[i] = 0; npages[i] = 0;
        endfunction

        // Works out the results of one accepted command and queues them.
        function void note_command(mode_t m, logic [ID_W-1:0] id, logic [ID_W-1:0] g,
                                   logic [PT_W-1:0] pt, logic [CAP_W-1:0] c, logic rev,
                                   logic usr, logic pz, logic [CPAGE_W-1:0] pg,
                                   logic [ADDR_W-1:0] va);
            slot_result_t res [$];
            slot_result_t r;
            int f;
            int live;
            logic answer;
            logic [63:0] stride;
            answer = 0;
            f = -1;
            case (m)
                MODE_MAP:
                begin
                    if (rev || !usr || pz || pg == 0 || pg > rpages || pt == 0)
                        res.push_back(plain(ST_REJECTED));
                    else
                    begin
                        for (int i = 0; i < NSLOT; i++)
                            if (f < 0 && !used[i])
                                f = i;
                        if (f < 0)
                            res.push_back(plain(ST_FULL));
                        else
                        begin
                            stride = ({47'b0, rpages} << PAGE_SHIFT_DEF) & MASK48;
                            used[f] = 1; owner[f] = id; gen[f] = g; cap[f] = c;
                            root[f] = pt; npages[f] = RPAGE_W'(pg);
                            addr[f] = ADDR_W'(({16'b0, base} + 64'(f) * stride) & MASK48);
                            r = plain(ST_OK);
                            r.mapped_va = addr[f];
                            res.push_back(r);
                        end
                    end
                end
                MODE_ROLLBACK, MODE_UNMAP:
                begin
                    for (int i = 0; i < NSLOT; i++)
                        if (f < 0 && used[i] && addr[i] == va &&
                            (m == MODE_ROLLBACK ? cap[i] == c : (owner[i] == id && gen[i] == g)))
                            f = i;
                    if (f >= 0)
                        res.push_back(release_slot(m == MODE_ROLLBACK ? ST_REJECTED : ST_OK, f));
                    else
                        res.push_back(plain(m == MODE_ROLLBACK ? ST_REJECTED : ST_NOT_FOUND));
                end
                MODE_INVAL, MODE_DRAIN, MODE_RESET:
                begin
                    for (int i = 0; i < NSLOT; i++)
                    begin
                        if (m == MODE_RESET)
                        begin
                            if (!used[i])
                                wipe(i);
                            else if (res.size() < MAX_RESULTS)
                            begin
                                res.push_back(release_slot(ST_OK, i));
                                wipe(i);
                            end
                        end
                        else if (res.size() < MAX_RESULTS && used[i] &&
                                 (m == MODE_INVAL ? cap[i] == c : owner[i] == id))
                            res.push_back(release_slot(ST_OK, i));
                    end
                    if (res.size() == 0)
                        res.push_back(plain(ST_OK));
                end
                MODE_COUNT:
                    res.push_back(plain(ST_OK));
                default:
                begin
                    for (int i = 0; i < NSLOT; i++)
                        if (used[i] && addr[i] == va && owner[i] == id && gen[i] == g)
                            answer = 1;
                    res.push_back(plain(ST_OK));
                end
            endcase
            live = 0;
            for (int i = 0; i < NSLOT; i++)
                live += used[i];
            foreach (res[k])
            begin
                res[k].tally = (m == MODE_IS_OWNER) ? TALLY_W'(answer) : TALLY_W'(live);
                res[k].last = (k == res.size() - 1);
                pending.push_back(res[k]);
            end
        endfunction

        function void check_result(logic [OUT_W-1:0] d, logic lst);
            slot_result_t e;
            if (pending.size() == 0)
            begin
                $error("result transfer with nothing expected: %h", d);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (d[1:0] != e.status)
            begin
                $error("status: expected %0d actual %0d", e.status, d[1:0]); errors++;
            end
            if (d[49:2] != e.mapped_va)
            begin
                $error("mapped_va: expected %h actual %h", e.mapped_va, d[49:2]); errors++;
            end
            if (d[66:50] != e.freed_pages)
            begin
                $error("freed_pages: expected %0d actual %0d", e.freed_pages, d[66:50]);
                errors++;
            end
            if (d[118:67] != e.freed_table)
            begin
                $error("freed_table: expected %h actual %h", e.freed_table, d[118:67]);
                errors++;
            end
            if (d[134:119] != e.release_cap)
            begin
                $error("release_cap: expected %h actual %h", e.release_cap, d[134:119]);
                errors++;
            end
            if (d[135] != e.release_valid)
            begin
                $error("release_valid: expected %0d actual %0d", e.release_valid, d[135]);
                errors++;
            end
            if (d[142:136] != e.tally)
            begin
                $error("tally: expected %0d actual %0d", e.tally, d[142:136]); errors++;
            end
            if (lst !== e.last)
            begin
                $error("last: expected %0d actual %0d", e.last, lst); errors++;
            end
        endfunction
    endclass

    logic              clk;
    logic              rst_n;
    logic              s_tvalid;
    logic              s_tready;
    logic [IN_W-1:0]   s_tdata;
    logic [2:0]        s_tuser;
    logic              m_tvalid;
    logic              m_tready;
    logic [OUT_W-1:0]  m_tdata;
    logic              m_tlast;
    logic              cfg_valid;
    logic              cfg_ready;
    logic              cfg_index;
    logic [ADDR_W-1:0] cfg_data;

    slot_registry_scoreboard sb;
    bit  rx_hold;
    int  idle_cycles;

    shared_region_slot_registry_core u_dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Result side: random stalls, plus one long hold-off on request.
    initial
    begin
        int g;
        m_tready <= 0;
        @(posedge rst_n);
        forever
        begin
            if (rx_hold)
            begin
                m_tready <= 0;
                repeat (400) @(posedge clk);
                rx_hold = 0;
            end
            g = pick_gap();
            if (g > 0)
            begin
                m_tready <= 0;
                repeat (g) @(posedge clk);
            end
            m_tready <= 1;
            @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        if (m_tvalid && m_tready)
            sb.check_result(m_tdata, m_tlast);
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == WATCHDOG_CYCLES)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic send_cmd(mode_t m, logic [ID_W-1:0] id, logic [ID_W-1:0] g,
                            logic [PT_W-1:0] pt, logic [CAP_W-1:0] c, logic rev, logic usr,
                            logic pz, logic [CPAGE_W-1:0] pg, logic [ADDR_W-1:0] va);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1;
        s_tuser  <= m;
        s_tdata  <= {1'b0, va, pg, pz, usr, rev, c, pt, g, id};
        do
            @(posedge clk);
        while (!(s_tvalid && s_tready));
        sb.note_command(m, id, g, pt, c, rev, usr, pz, pg, va);
    endtask

    task automatic drain_results();
        s_tvalid <= 0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, logic [ADDR_W-1:0] value);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!(cfg_valid && cfg_ready));
        cfg_valid <= 0;
        sb.write_reg(idx, value);
    endtask

    task automatic set_window(logic [ADDR_W-1:0] b, logic [RPAGE_W-1:0] rp);
        drain_results();
        write_reg(REG_WINDOW_BASE, b);
        write_reg(REG_REGION_PAGES, {31'b0, rp});
    endtask

    function automatic logic [ID_W-1:0] pick_id();
        logic [ID_W-1:0] pool [4] = '{32'd0, 32'd1, 32'd5, 32'hFFFF_FFFF};
        return ($urandom_range(0, 9) < 8) ? pool[$urandom_range(0, 3)] : $urandom;
    endfunction

    function automatic logic [CAP_W-1:0] pick_cap();
        logic [CAP_W-1:0] pool [4] = '{16'd0, 16'd3, 16'hFFFF, 16'h1234};
        return ($urandom_range(0, 9) < 8) ? pool[$urandom_range(0, 3)] : CAP_W'($urandom);
    endfunction

    // Mostly well-formed maps and hits on live slots, with some noise mixed in.
    task automatic random_cmd();
        mode_t m;
        int r, s;
        logic [ID_W-1:0] id, g;
        logic [PT_W-1:0] pt;
        logic [CAP_W-1:0] c;
        logic rev, usr, pz;
        logic [CPAGE_W-1:0] pg;
        logic [ADDR_W-1:0] va;
        r = $urandom_range(0, 99);
        m = r < 35 ? MODE_MAP : r < 43 ? MODE_ROLLBACK : r < 63 ? MODE_UNMAP :
            r < 71 ? MODE_INVAL : r < 79 ? MODE_DRAIN : r < 83 ? MODE_RESET :
            r < 90 ? MODE_COUNT : MODE_IS_OWNER;
        id = pick_id();
        g = ($urandom_range(0, 9) < 7) ? ID_W'($urandom_range(0, 2)) : $urandom;
        c = pick_cap();
        pt = PT_W'({$urandom, $urandom});
        if ($urandom_range(0, 19) == 0)
            pt = '0;
        rev = ($urandom_range(0, 19) == 0);
        usr = ($urandom_range(0, 19) != 0);
        pz = ($urandom_range(0, 19) == 0);
        if ($urandom_range(0, 9) == 0 || sb.rpages == 0)
            pg = CPAGE_W'($urandom);
        else
            pg = CPAGE_W'($urandom_range(1, sb.rpages > 65535 ? 65535 : sb.rpages));
        va = ADDR_W'({$urandom, $urandom});
        s = $urandom_range(0, NSLOT - 1);
        if ($urandom_range(0, 3) != 0 && sb.used[s])
        begin
            va = sb.addr[s];
            if (m == MODE_ROLLBACK || m == MODE_INVAL)
                c = sb.cap[s];
            if ($urandom_range(0, 4) != 0)
            begin
                id = sb.owner[s];
                g = sb.gen[s];
            end
        end
        send_cmd(m, id, g, pt, c, rev, usr, pz, pg, va);
    endtask

    initial
    begin
        logic [PT_W-1:0] ptx;
        sb = new();
        rx_hold = 0;
        idle_cycles = 0;
        rst_n = 0;
        s_tvalid <= 0; s_tuser <= '0; s_tdata <= '0;
        cfg_valid <= 0; cfg_index <= 0; cfg_data <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Top of the window so that slot addresses wrap.
        set_window(48'hFFFF_FFFF_E000, 17'd1);
        ptx = 52'hF_FFFF_FFFF_FFFF;
        send_cmd(MODE_COUNT, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        send_cmd(MODE_RESET, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        send_cmd(MODE_MAP, 1, 1, 0, 1, 0, 1, 0, 1, 0);
        send_cmd(MODE_MAP, 1, 1, ptx, 1, 1, 1, 0, 1, 0);
        send_cmd(MODE_MAP, 1, 1, ptx, 1, 0, 0, 0, 1, 0);
        send_cmd(MODE_MAP, 1, 1, ptx, 1, 0, 1, 1, 1, 0);
        send_cmd(MODE_MAP, 1, 1, ptx, 1, 0, 1, 0, 0, 0);
        send_cmd(MODE_MAP, 1, 1, ptx, 1, 0, 1, 0, 2, 0);
        for (int i = 0; i < NSLOT + 1; i++)
            send_cmd(MODE_MAP, i % 3, 32'hFFFF_FFFF, ptx - i, CAP_W'(i % 4), 0, 1, 0, 1, 0);
        send_cmd(MODE_IS_OWNER, 0, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0, sb.addr[0]);
        send_cmd(MODE_UNMAP, 1, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0, sb.addr[0]);
        send_cmd(MODE_UNMAP, 0, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0, sb.addr[0]);
        send_cmd(MODE_ROLLBACK, 0, 0, 0, 16'hFFFF, 0, 0, 0, 0, sb.addr[1]);
        send_cmd(MODE_ROLLBACK, 0, 0, 0, 1, 0, 0, 0, 0, sb.addr[1]);
        send_cmd(MODE_INVAL, 0, 0, 0, 2, 0, 0, 0, 0, 0);
        send_cmd(MODE_INVAL, 0, 0, 0, 9, 0, 0, 0, 0, 0);
        send_cmd(MODE_DRAIN, 2, 0, 0, 0, 0, 0, 0, 0, 0);
        send_cmd(MODE_DRAIN, 7, 0, 0, 0, 0, 0, 0, 0, 0);
        send_cmd(MODE_RESET, 0, 0, 0, 0, 0, 0, 0, 0, 0);

        set_window('0, 17'd65536);
        rx_hold = 1;
        repeat (100) random_cmd();
        set_window(48'hFFFF_FFFF_FFFF, 17'd0);
        repeat (40) random_cmd();
        set_window(ADDR_W'({$urandom, $urandom}), RPAGE_W'($urandom_range(1, 16)));
        repeat (120) random_cmd();
        set_window(ADDR_W'({$urandom, $urandom}), RPAGE_W'($urandom));
        repeat (120) random_cmd();

        drain_results();
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
`default_nettype wire
